// File: hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, suspended while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Property checked at every rising edge, reset included.
`define ASSERT_CLK(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// File: hdl/sdmm_pkg.sv
package sdmm_pkg;

  localparam int MAX_ROWS  = 64;
  localparam int MAX_INNER = 64;
  localparam int MAX_COLS  = 16;

  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int INNER_W = $clog2(MAX_INNER);
  localparam int COL_W   = $clog2(MAX_COLS);

  localparam int C_AW    = ROW_W + COL_W;
  localparam int B_AW    = INNER_W + COL_W;
  localparam int C_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int B_DEPTH = MAX_INNER * MAX_COLS;

  localparam int VAL_W  = 16;
  localparam int PROD_W = 2 * VAL_W;
  localparam int ACC_W  = 40;
  localparam int IDX_W  = 6;
  localparam int DIM_W  = 7;
  localparam int NCOL_W = 5;
  localparam int KIND_W = 2;
  localparam int CFG_IW = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_B = 2'd0,
    KIND_MAC    = 2'd1,
    KIND_READ_C = 2'd2
  } kind_t;

  typedef enum logic [CFG_IW-1:0] {
    CFG_ROWS  = 2'd0,
    CFG_INNER = 2'd1,
    CFG_COLS  = 2'd2
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_READ,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [DIM_W-1:0]  rows;
    logic [DIM_W-1:0]  inner;
    logic [NCOL_W-1:0] cols;
  } dims_t;

  typedef struct packed {
    logic            valid;
    logic [C_AW-1:0] addr;
  } mac_issue_t;

  typedef struct packed {
    logic             we;
    logic [C_AW-1:0]  addr;
    logic [ACC_W-1:0] data;
  } c_wr_t;

endpackage

// File: hdl/sdmm_ram.sv
module sdmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first: a read and a write of the same entry return the old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/sdmm_mac.sv
module sdmm_mac
  import sdmm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  mac_issue_t              issue,
  input  logic signed [VAL_W-1:0] value,
  input  logic signed [VAL_W-1:0] b_rdata,
  input  logic signed [ACC_W-1:0] c_rdata,
  output c_wr_t                   wr,
  output logic                    busy
);

  logic                     p1_valid;
  logic [C_AW-1:0]          p1_addr;
  logic                     p2_valid;
  logic [C_AW-1:0]          p2_addr;
  logic signed [PROD_W-1:0] p2_prod;
  logic signed [ACC_W-1:0]  p2_acc;
  logic signed [ACC_W:0]    sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
    end else begin
      p1_valid <= issue.valid;
      p2_valid <= p1_valid;
    end
    p1_addr <= issue.addr;
    p2_addr <= p1_addr;
    p2_prod <= value * b_rdata;
    p2_acc  <= c_rdata;
  end

  assign sum = {p2_acc[ACC_W-1], p2_acc} + (ACC_W+1)'(p2_prod);

  always_comb begin
    wr.we   = p2_valid;
    wr.addr = p2_addr;
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      wr.data = {sum[ACC_W], {(ACC_W-1){~sum[ACC_W]}}};
    end else begin
      wr.data = sum[ACC_W-1:0];
    end
  end

  assign busy = p1_valid | p2_valid;

endmodule

// File: hdl/sdmm_seq.sv
module sdmm_seq
  import sdmm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  dims_t             dims,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [IDX_W-1:0]  in_row,
  input  logic [IDX_W-1:0]  in_col,
  input  logic [VAL_W-1:0]  in_value,
  input  logic              mac_busy,
  input  logic              out_valid,
  output logic              out_load,
  output logic [IDX_W-1:0]  item_row,
  output logic [COL_W-1:0]  item_col,
  output logic [VAL_W-1:0]  item_value,
  output mac_issue_t        issue,
  output c_wr_t             c_wr,
  output logic [C_AW-1:0]   c_raddr,
  output logic              b_we,
  output logic [B_AW-1:0]   b_waddr,
  output logic [VAL_W-1:0]  b_wdata,
  output logic [B_AW-1:0]   b_raddr
);

  state_t            state;
  state_t            state_next;
  logic [COL_W-1:0]  j;
  logic [COL_W-1:0]  j_next;
  logic [C_AW-1:0]   clr_addr;
  logic [IDX_W-1:0]  row_q;
  logic [IDX_W-1:0]  col_q;
  logic [VAL_W-1:0]  value_q;
  logic              accept;
  logic              load_ok;
  logic              mac_ok;
  logic              read_ok;
  logic              j_last;

  assign accept = in_valid && in_ready;

  assign load_ok = (kind_t'(in_kind) == KIND_LOAD_B) && (DIM_W'(in_row) < dims.inner)
                   && (DIM_W'(in_col) < DIM_W'(dims.cols));
  assign mac_ok  = (kind_t'(in_kind) == KIND_MAC) && (DIM_W'(in_row) < dims.rows)
                   && (DIM_W'(in_col) < dims.inner) && (dims.cols != '0);
  assign read_ok = (kind_t'(in_kind) == KIND_READ_C) && (DIM_W'(in_row) < dims.rows)
                   && (DIM_W'(in_col) < DIM_W'(dims.cols));
  assign j_last  = (NCOL_W'(j) == dims.cols - NCOL_W'(1));

  always_comb begin
    state_next = state;
    j_next     = j;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == C_AW'(C_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        j_next = '0;
        if (accept && mac_ok) begin
          state_next = ST_MAC;
        end else if (accept && read_ok) begin
          state_next = ST_READ;
        end
      end
      ST_MAC: begin
        j_next = j + COL_W'(1);
        if (j_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!mac_busy) begin
          state_next = ST_IDLE;
        end
      end
      ST_READ: begin
        // The result register must be empty before the entry is read and cleared.
        if (!out_valid) begin
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready    = (state == ST_IDLE);
    out_load    = (state == ST_RESP);
    issue.valid = (state == ST_MAC);
    issue.addr  = {row_q[ROW_W-1:0], j};
    c_raddr     = (state == ST_MAC) ? {row_q[ROW_W-1:0], j}
                                    : {row_q[ROW_W-1:0], col_q[COL_W-1:0]};
    b_raddr     = {col_q[INNER_W-1:0], j};
    c_wr.data   = '0;
    case (state)
      ST_CLEAR: begin
        c_wr.we   = 1'b1;
        c_wr.addr = clr_addr;
      end
      ST_READ: begin
        c_wr.we   = !out_valid;
        c_wr.addr = {row_q[ROW_W-1:0], col_q[COL_W-1:0]};
      end
      default: begin
        c_wr.we   = 1'b0;
        c_wr.addr = clr_addr;
      end
    endcase
    b_we    = accept && load_ok;
    b_waddr = {in_row[INNER_W-1:0], in_col[COL_W-1:0]};
    b_wdata = in_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      j        <= '0;
    end else begin
      state <= state_next;
      j     <= j_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + C_AW'(1);
      end
    end
    if (accept) begin
      row_q   <= in_row;
      col_q   <= in_col;
      value_q <= in_value;
    end
  end

  assign item_row   = row_q;
  assign item_col   = col_q[COL_W-1:0];
  assign item_value = value_q;

endmodule

// File: hdl/sparse_dense_matrix_multiply_core.sv
// Kind 0 (load B) is written into the B memory as it is taken; kind 2 (read and clear C)
// waits for an empty output register, then reads and clears the entry. Kind 1 (nonzero)
// sends each used C column, one per cycle, through a read, multiply and saturating add
// pipeline on the C memory, then drains it. A result waits in the output register while
// the next item is taken. Synchronous reset clears control state and then sweeps all C
// entries to zero while s_axis_tready stays low; configuration returns to 64/64/16.
module sparse_dense_matrix_multiply_core
  import sdmm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CFG_IW-1:0]   cfg_index,
  input  logic [DIM_W-1:0]    cfg_data,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [31:0]         s_axis_tdata,  // row[5:0], col[11:6], value[27:12]
  input  logic [KIND_W-1:0]   s_axis_tuser,  // kind[1:0]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [55:0]         m_axis_tdata   // result_value[39:0], result_row[45:40],
                                             // result_col[49:46]
);

  logic [DIM_W-1:0]  rows_used;
  logic [DIM_W-1:0]  inner_used;
  logic [NCOL_W-1:0] cols_used;
  dims_t             dims;

  logic              out_valid;
  logic [ACC_W-1:0]  out_value;
  logic [IDX_W-1:0]  out_row;
  logic [COL_W-1:0]  out_col;

  logic              out_load;
  logic [IDX_W-1:0]  item_row;
  logic [COL_W-1:0]  item_col;
  logic [VAL_W-1:0]  item_value;
  mac_issue_t        issue;
  c_wr_t             seq_cwr;
  c_wr_t             mac_cwr;
  c_wr_t             c_wr;
  logic [C_AW-1:0]   c_raddr;
  logic [ACC_W-1:0]  c_rdata;
  logic              b_we;
  logic [B_AW-1:0]   b_waddr;
  logic [VAL_W-1:0]  b_wdata;
  logic [B_AW-1:0]   b_raddr;
  logic [VAL_W-1:0]  b_rdata;
  logic              mac_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_used  <= DIM_W'(64);
      inner_used <= DIM_W'(64);
      cols_used  <= NCOL_W'(16);
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_ROWS:  rows_used  <= cfg_data;
        CFG_INNER: inner_used <= cfg_data;
        CFG_COLS:  cols_used  <= cfg_data[NCOL_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    dims.rows  = (rows_used > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : rows_used;
    dims.inner = (inner_used > DIM_W'(MAX_INNER)) ? DIM_W'(MAX_INNER) : inner_used;
    dims.cols  = (cols_used > NCOL_W'(MAX_COLS)) ? NCOL_W'(MAX_COLS) : cols_used;
  end

  sdmm_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .dims       (dims),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_kind    (s_axis_tuser),
    .in_row     (s_axis_tdata[5:0]),
    .in_col     (s_axis_tdata[11:6]),
    .in_value   (s_axis_tdata[27:12]),
    .mac_busy   (mac_busy),
    .out_valid  (out_valid),
    .out_load   (out_load),
    .item_row   (item_row),
    .item_col   (item_col),
    .item_value (item_value),
    .issue      (issue),
    .c_wr       (seq_cwr),
    .c_raddr    (c_raddr),
    .b_we       (b_we),
    .b_waddr    (b_waddr),
    .b_wdata    (b_wdata),
    .b_raddr    (b_raddr)
  );

  sdmm_mac u_mac (
    .clk     (clk),
    .rst     (rst),
    .issue   (issue),
    .value   (item_value),
    .b_rdata (b_rdata),
    .c_rdata (c_rdata),
    .wr      (mac_cwr),
    .busy    (mac_busy)
  );

  // The sequencer and the multiply pipeline never write C in the same cycle.
  assign c_wr = mac_cwr.we ? mac_cwr : seq_cwr;

  sdmm_ram #(
    .WIDTH (VAL_W),
    .DEPTH (B_DEPTH)
  ) u_b_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  sdmm_ram #(
    .WIDTH (ACC_W),
    .DEPTH (C_DEPTH)
  ) u_c_ram (
    .clk   (clk),
    .we    (c_wr.we),
    .waddr (c_wr.addr),
    .wdata (c_wr.data),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_value <= c_rdata;
      out_row   <= item_row;
      out_col   <= item_col;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'b0, out_col, out_row, out_value};

endmodule

// File: hdl/sdmm_checker.sv
`include "assert_macros.svh"

module sdmm_checker
  import sdmm_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic [KIND_W-1:0] s_axis_tuser,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [55:0]       m_axis_tdata
);

  // The C memory is swept after reset, so no item is taken right after it.
  `ASSERT_CLK(a_clear_after_reset, clk, rst |=> !s_axis_tready)

  // A result only appears after the input side was closed.
  `ASSERT_CLK_RST(a_result_after_busy, clk, rst, $rose(m_axis_tvalid) |-> $past(!s_axis_tready))

  // A load of B never produces a result in the following cycle.
  `ASSERT_CLK_RST(a_load_no_result, clk, rst, s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_LOAD_B) |=> !$rose(m_axis_tvalid))

  // A stalled result holds its data.
  `ASSERT_CLK_RST(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind sparse_dense_matrix_multiply_core sdmm_checker u_sdmm_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
